@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define NSCC_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the next cycle, outside reset.
`define NSCC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is held.
`define NSCC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/nscc_pkg.sv @@
// Shared types and constants of the nearest set cell search block.
`default_nettype none

package nscc_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WMOD,
    ST_SCAN,
    ST_DRAIN,
    ST_OUT
  } state_t;

  // Configuration register indexes
  localparam logic REG_ROWS_IN_USE = 1'b0;
  localparam logic REG_COLS_IN_USE = 1'b1;

  // Input action codes
  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  // Largest reported distance and register reset values
  localparam logic [4:0] DIST_MAX   = 5'd31;
  localparam logic [5:0] ROWS_RESET = 6'd32;
  localparam logic [5:0] COLS_RESET = 6'd32;

endpackage

`default_nettype wire

@@ rtl/nscc_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module nscc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/nscc_row_dist.sv @@
// Shared row evaluator: Chebyshev distance from the query to the nearest set bit of one row.
`default_nettype none

module nscc_row_dist #(
  parameter int MAX_COLS = 32,
  parameter int DW       = 5
) (
  input  wire logic [MAX_COLS-1:0] word,
  input  wire logic [4:0]          col,
  input  wire logic [DW-1:0]       di,
  output logic                     hit,
  output logic      [DW-1:0]       cheb_dist
);

  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CDW = (CIW > 5) ? CIW : 5;

  logic [CDW-1:0] c_ext;
  logic           left_hit;
  logic           right_hit;
  logic [CDW-1:0] jl;
  logic [CDW-1:0] jr;
  logic [CDW-1:0] dl;
  logic [CDW-1:0] dr;
  logic [CDW-1:0] dj;
  logic [DW-1:0]  dj_ext;

  assign c_ext = CDW'(col);

  // Find the closest set bit at or left of the query column, and at or right of it
  always_comb begin
    left_hit  = 1'b0;
    right_hit = 1'b0;
    jl        = '0;
    jr        = '0;
    for (int j = 0; j < MAX_COLS; j++) begin
      if (word[j] && (CDW'(j) <= c_ext)) begin
        left_hit = 1'b1;
        jl       = CDW'(j);
      end
    end
    for (int j = MAX_COLS - 1; j >= 0; j--) begin
      if (word[j] && (CDW'(j) >= c_ext)) begin
        right_hit = 1'b1;
        jr        = CDW'(j);
      end
    end
  end

  // Take the nearer column, then the larger of row and column distance
  always_comb begin
    dl = c_ext - jl;
    dr = jr - c_ext;
    if (left_hit && right_hit) begin
      dj = (dl < dr) ? dl : dr;
    end else if (left_hit) begin
      dj = dl;
    end else begin
      dj = dr;
    end
    dj_ext    = DW'(dj);
    hit       = left_hit | right_hit;
    cheb_dist = (di > dj_ext) ? di : dj_ext;
  end

endmodule

`default_nettype wire

@@ rtl/nearest_set_cell_chebyshev.sv @@
// Top level: bitmap grid with nearest set cell search by Chebyshev distance.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+--------------------------------------
//   in      | input     | in_valid / in_stall | in_action, in_row, in_col, in_cell_value
//   out     | output    | out_valid/out_stall | out_distance, out_none_found
//   cfg     | input     | cfg_we              | cfg_idx, cfg_wdata
//
// A query is accepted, the grid RAM is read once per row in use, N = min(rows_in_use, MAX_ROWS),
// and the last row's evaluation ends in the drain state; with N = 0 the query goes straight to the result.
// The grid RAM's single read port and the one shared row evaluator make the scan go row by row.
// A write reads its row and writes it back; a write outside the area in use is ignored.
// Reset is synchronous; per-row valid bits make the grid read as zero with no clearing pass.
// in_stall stays high while a transaction is at work or its result waits on out_stall.
`default_nettype none

module nearest_set_cell_chebyshev #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic       in_action,
  input  wire logic [4:0] in_row,
  input  wire logic [4:0] in_col,
  input  wire logic       in_cell_value,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic      [4:0] out_distance,
  output logic            out_none_found,
  input  wire logic       cfg_we,
  input  wire logic       cfg_idx,
  input  wire logic [5:0] cfg_wdata
);

  localparam int RIW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int RDW = (RIW > 5) ? RIW : 5;
  localparam int CIW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CDW = (CIW > 5) ? CIW : 5;
  localparam int DW  = (RDW > CDW) ? RDW : CDW;
  localparam int RCW = $clog2(MAX_ROWS + 1);
  localparam int NRW = (RCW > 6) ? RCW : 6;
  localparam int NCW = 7;

  nscc_pkg::state_t state_r, state_nxt;

  logic [5:0]          rows_r, cols_r;
  logic [4:0]          pos_row_r, pos_row_nxt;
  logic [4:0]          pos_col_r, pos_col_nxt;
  logic                val_r, val_nxt;
  logic [NRW-1:0]      scan_r, scan_nxt;
  logic [RIW-1:0]      rd_row_r, rd_row_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                rd_fill_r, rd_fill_nxt;
  logic [MAX_ROWS-1:0] row_vld_r, row_vld_nxt;
  logic [DW-1:0]       best_r, best_nxt;
  logic                found_r, found_nxt;

  logic [NRW-1:0]      nr_eff;
  logic [NCW-1:0]      nc_eff;
  logic                in_fire;
  logic                wr_ok;
  logic                scan_last;
  logic                ram_re, ram_we;
  logic [RIW-1:0]      ram_raddr, ram_waddr;
  logic [MAX_COLS-1:0] ram_rdata, ram_wdata;
  logic [MAX_COLS-1:0] col_mask;
  logic [MAX_COLS-1:0] row_word;
  logic [MAX_COLS-1:0] eval_word;
  logic [RDW-1:0]      ra, rb, di_raw;
  logic [DW-1:0]       di;
  logic                eval_hit;
  logic [DW-1:0]       eval_dist;

  // Area in use, clipped to the grid size
  assign nr_eff = (NRW'(rows_r) > NRW'(MAX_ROWS)) ? NRW'(MAX_ROWS) : NRW'(rows_r);
  assign nc_eff = (NCW'(cols_r) > NCW'(MAX_COLS)) ? NCW'(MAX_COLS) : NCW'(cols_r);

  assign in_fire   = in_valid && !in_stall;
  assign wr_ok     = (NRW'(in_row) < nr_eff) && (NCW'(in_col) < nc_eff);
  assign scan_last = (scan_r + NRW'(1)) >= nr_eff;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= nscc_pkg::ROWS_RESET;
      cols_r <= nscc_pkg::COLS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        nscc_pkg::REG_ROWS_IN_USE: rows_r <= cfg_wdata;
        nscc_pkg::REG_COLS_IN_USE: cols_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      nscc_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_action == nscc_pkg::ACT_WRITE) begin
            state_nxt = wr_ok ? nscc_pkg::ST_WMOD : nscc_pkg::ST_IDLE;
          end else begin
            state_nxt = (nr_eff == '0) ? nscc_pkg::ST_OUT : nscc_pkg::ST_SCAN;
          end
        end
      end
      nscc_pkg::ST_WMOD:  state_nxt = nscc_pkg::ST_IDLE;
      nscc_pkg::ST_SCAN:  state_nxt = scan_last ? nscc_pkg::ST_DRAIN : nscc_pkg::ST_SCAN;
      nscc_pkg::ST_DRAIN: state_nxt = nscc_pkg::ST_OUT;
      nscc_pkg::ST_OUT:   state_nxt = out_stall ? nscc_pkg::ST_OUT : nscc_pkg::ST_IDLE;
      default:            state_nxt = nscc_pkg::ST_IDLE;
    endcase
  end

  // Handshake and RAM control
  always_comb begin
    in_stall  = (state_r != nscc_pkg::ST_IDLE);
    out_valid = (state_r == nscc_pkg::ST_OUT);
    ram_re    = 1'b0;
    ram_raddr = RIW'(in_row);
    ram_we    = (state_r == nscc_pkg::ST_WMOD);
    ram_waddr = RIW'(pos_row_r);
    unique case (state_r)
      nscc_pkg::ST_IDLE: begin
        ram_re = in_fire && (in_action == nscc_pkg::ACT_WRITE) && wr_ok;
      end
      nscc_pkg::ST_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = scan_r[RIW-1:0];
      end
      default: ;
    endcase
  end

  // Result fields: saturate the distance, zero it when nothing was found
  always_comb begin
    out_none_found = !found_r;
    if (!found_r) begin
      out_distance = '0;
    end else if (best_r > DW'(nscc_pkg::DIST_MAX)) begin
      out_distance = nscc_pkg::DIST_MAX;
    end else begin
      out_distance = best_r[4:0];
    end
  end

  // Columns in use; never-written rows read as zero
  always_comb begin
    for (int j = 0; j < MAX_COLS; j++) begin
      col_mask[j] = NCW'(j) < nc_eff;
    end
  end

  assign row_word  = rd_fill_r ? ram_rdata : '0;
  assign eval_word = row_word & col_mask;

  // Row distance of the row under evaluation
  assign ra     = RDW'(rd_row_r);
  assign rb     = RDW'(pos_row_r);
  assign di_raw = (ra > rb) ? (ra - rb) : (rb - ra);
  assign di     = DW'(di_raw);

  // Modify one bit of the row read back
  always_comb begin
    ram_wdata = row_word;
    ram_wdata[CIW'(pos_col_r)] = val_r;
  end

  // Datapath next values
  always_comb begin
    pos_row_nxt = pos_row_r;
    pos_col_nxt = pos_col_r;
    val_nxt     = val_r;
    scan_nxt    = scan_r;
    rd_row_nxt  = rd_row_r;
    rd_vld_nxt  = (state_r == nscc_pkg::ST_SCAN);
    rd_fill_nxt = rd_fill_r;
    row_vld_nxt = row_vld_r;
    best_nxt    = best_r;
    found_nxt   = found_r;

    // Capture the transaction
    if (in_fire) begin
      pos_row_nxt = in_row;
      pos_col_nxt = in_col;
      val_nxt     = in_cell_value;
      scan_nxt    = '0;
      if (in_action == nscc_pkg::ACT_QUERY) begin
        best_nxt  = '0;
        found_nxt = 1'b0;
      end
    end

    // Track which row is read and whether it was ever written
    if (ram_re) begin
      rd_row_nxt  = ram_raddr;
      rd_fill_nxt = row_vld_r[ram_raddr];
    end

    // Advance the scan
    if (state_r == nscc_pkg::ST_SCAN) begin
      scan_nxt = scan_r + NRW'(1);
    end

    // Fold the evaluated row into the running minimum
    if (rd_vld_r && eval_hit && (!found_r || (eval_dist < best_r))) begin
      best_nxt = eval_dist;
    end
    if (rd_vld_r && eval_hit) begin
      found_nxt = 1'b1;
    end

    // Mark a written row valid
    if (ram_we) begin
      row_vld_nxt[ram_waddr] = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= nscc_pkg::ST_IDLE;
      rd_vld_r  <= 1'b0;
      row_vld_r <= '0;
      found_r   <= 1'b0;
      scan_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      rd_vld_r  <= rd_vld_nxt;
      row_vld_r <= row_vld_nxt;
      found_r   <= found_nxt;
      scan_r    <= scan_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    pos_row_r <= pos_row_nxt;
    pos_col_r <= pos_col_nxt;
    val_r     <= val_nxt;
    rd_row_r  <= rd_row_nxt;
    rd_fill_r <= rd_fill_nxt;
    best_r    <= best_nxt;
  end

  nscc_ram #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  nscc_row_dist #(
    .MAX_COLS (MAX_COLS),
    .DW       (DW)
  ) u_row_dist (
    .word      (eval_word),
    .col       (pos_col_r),
    .di        (di),
    .hit       (eval_hit),
    .cheb_dist (eval_dist)
  );

endmodule

`default_nettype wire

@@ rtl/nscc_checker.sv @@
// Port-level checker for the nearest set cell block, bound to the top level.
`default_nettype none

`include "assert_macros.svh"

module nscc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic       in_action,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [4:0] out_distance,
  input wire logic       out_none_found
);

  // Hold a stalled result
  `NSCC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_distance) && $stable(out_none_found), "stalled result changed")

  // Report distance zero when nothing was found
  `NSCC_ASSERT_IMPL(a_none_zero, out_valid && out_none_found, out_distance == 5'd0,
    "none_found with nonzero distance")

  // Accept no transaction while a result waits
  `NSCC_ASSERT_IMPL(a_busy_out, out_valid, in_stall, "input accepted while result pending")

  // Produce no result right after a write transaction
  `NSCC_ASSERT_NEXT(a_write_silent,
    in_valid && !in_stall && (in_action == nscc_pkg::ACT_WRITE), !out_valid,
    "write transaction produced a result")

  // Drop any result during reset
  `NSCC_ASSERT_NEXT_ALWAYS(a_reset_idle, !rst_n, !out_valid, "result shown after reset")

endmodule

bind nearest_set_cell_chebyshev nscc_checker u_nscc_checker (.*);

`default_nettype wire
